>>> src/ttrig_pkg.sv
// Package for the Taylor-series trig evaluator: fixed-point constants,
// internal widths, function codes and the pipeline control word.
// No dependencies.
`timescale 1ns / 1ps
package ttrig_pkg;

    localparam int FRAC_BITS = 24;
    localparam logic [63:0] PI_Q      = 64'd52707179;
    localparam logic [63:0] HALF_PI_Q = 64'd26353589;
    localparam logic [63:0] TWO_PI_Q  = 64'd105414358;

    localparam int RED_W = 29;
    localparam int X2_W  = 28;
    localparam int T_W   = 32;
    localparam int NB    = X2_W + T_W + 1 - FRAC_BITS;
    localparam int NUM_W = 51;
    localparam int DEN_W = 28;

    localparam logic [T_W-1:0] ONE_Q = T_W'(64'd1 << FRAC_BITS);

    localparam logic [1:0] ACT_COS = 2'd0;
    localparam logic [1:0] ACT_SIN = 2'd1;
    localparam logic [1:0] ACT_TAN = 2'd2;
    localparam logic [1:0] ACT_COT = 2'd3;

    typedef struct packed {
        logic                  valid;
        logic [1:0]            action;
        logic                  asign;
        logic signed [T_W-1:0] val;
        logic                  nneg;
        logic                  qneg;
        logic                  dz;
    } t_ctrl;

endpackage

>>> src/taylor_trig_evaluator.sv
// Top level of the Taylor-series trig evaluator: reduction, series and quotient chains.
// Uses ttrig_pkg, ttrig_mod_cell, ttrig_series_cell and ttrig_div_cell.
//
// One beat is taken every cycle; busy stays low. A result appears on o_value and
// o_saturated with o_valid high for one cycle. The receiver cannot stall the block,
// so it must take every result in the cycle that o_valid marks. The pipeline is made
// of the reduction chain (one cell per quotient bit of angle / two pi), one fold and
// one square stage, three stages per series term, one operand stage, the 51-cell
// restoring quotient chain that tangent and cotangent need, and the output register.
`timescale 1ns / 1ps
module taylor_trig_evaluator #(
    parameter int DATA_WIDTH   = 32,
    parameter int SERIES_TERMS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_angle,
    input  logic [1:0]            i_action,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic                  o_saturated
);
    import ttrig_pkg::*;

    localparam int MW        = (DATA_WIDTH > RED_W) ? DATA_WIDTH : RED_W;
    localparam int MOD_STEPS = (DATA_WIDTH > 28) ? DATA_WIDTH - 27 : 1;
    localparam int P         = MOD_STEPS + 2 + 3 * SERIES_TERMS;
    localparam int L         = P + NUM_W + 1;
    localparam logic signed [64:0] WMAX = (65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1;
    localparam logic signed [64:0] WMIN = -WMAX - 65'sd1;
    localparam logic signed [RED_W-1:0] PI_S  = RED_W'(PI_Q);
    localparam logic signed [RED_W-1:0] HPI_S = RED_W'(HALF_PI_Q);
    localparam logic signed [RED_W-1:0] TPI_S = RED_W'(TWO_PI_Q);

    t_ctrl r_ctl [L];
    t_ctrl n_ctl [L];

    logic [MW-1:0] w_mag [MOD_STEPS+1];
    logic [MW-1:0] n_amag;

    logic signed [RED_W-1:0] r_rc, r_rs;
    logic signed [RED_W-1:0] n_r0, n_r1, n_h0, n_h1;
    logic [X2_W-1:0] r_x2c, r_x2s;
    logic [RED_W-1:0] n_mc, n_ms;
    logic [2*RED_W-1:0] n_sqc, n_sqs;

    logic [X2_W-1:0]       w_cx [SERIES_TERMS+1];
    logic signed [T_W-1:0] w_ct [SERIES_TERMS+1];
    logic [X2_W-1:0]       w_sx [SERIES_TERMS+1];
    logic signed [T_W-1:0] w_st [SERIES_TERMS+1];

    logic signed [T_W-1:0] n_num, n_den;
    logic [T_W-1:0]        n_nmag, n_dmag;
    logic [NUM_W-1:0]      r_pnum;
    logic [DEN_W-1:0]      r_pden;

    logic [DEN_W-1:0] w_rem [NUM_W+1];
    logic [NUM_W-1:0] w_num [NUM_W+1];
    logic [NUM_W-1:0] w_quo [NUM_W+1];
    logic [DEN_W-1:0] w_den [NUM_W+1];

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_value;
    logic                  r_sat;
    logic signed [64:0]    n_v;
    logic [DATA_WIDTH-1:0] n_value;
    logic                  n_sat;
    t_ctrl                 w_last;

    assign busy = 1'b0;

    // reduction chain
    assign n_amag = i_angle[DATA_WIDTH-1] ? MW'(DATA_WIDTH'(-i_angle)) : MW'(i_angle);
    assign w_mag[0] = n_amag;

    genvar gi;
    for (gi = 0; gi < MOD_STEPS; gi++) begin : g_mod
        ttrig_mod_cell #(
            .MW  (MW),
            .SUB (TWO_PI_Q << (MOD_STEPS - 1 - gi))
        ) u_cell (
            .i_clk (i_clk),
            .i_mag (w_mag[gi]),
            .o_mag (w_mag[gi+1])
        );
    end

    // fold into (-pi, pi] and form the sine argument
    always_comb begin
        n_r0 = r_ctl[MOD_STEPS-1].asign ? -$signed(w_mag[MOD_STEPS][RED_W-1:0])
                                        : $signed(w_mag[MOD_STEPS][RED_W-1:0]);
        if (n_r0 > PI_S) begin
            n_r1 = n_r0 - TPI_S;
        end else if (n_r0 <= -PI_S) begin
            n_r1 = n_r0 + TPI_S;
        end else begin
            n_r1 = n_r0;
        end
        n_h0 = HPI_S - n_r1;
        if (n_h0 > PI_S) begin
            n_h1 = n_h0 - TPI_S;
        end else if (n_h0 <= -PI_S) begin
            n_h1 = n_h0 + TPI_S;
        end else begin
            n_h1 = n_h0;
        end
        n_mc  = r_rc[RED_W-1] ? RED_W'(-r_rc) : RED_W'(r_rc);
        n_ms  = r_rs[RED_W-1] ? RED_W'(-r_rs) : RED_W'(r_rs);
        n_sqc = {{RED_W{1'b0}}, n_mc} * {{RED_W{1'b0}}, n_mc};
        n_sqs = {{RED_W{1'b0}}, n_ms} * {{RED_W{1'b0}}, n_ms};
    end

    always_ff @(posedge i_clk) begin
        r_rc  <= n_r1;
        r_rs  <= n_h1;
        r_x2c <= n_sqc[FRAC_BITS+X2_W-1:FRAC_BITS];
        r_x2s <= n_sqs[FRAC_BITS+X2_W-1:FRAC_BITS];
    end

    // series chains
    assign w_cx[0] = r_x2c;
    assign w_ct[0] = $signed(ONE_Q);
    assign w_sx[0] = r_x2s;
    assign w_st[0] = $signed(ONE_Q);

    for (gi = 0; gi < SERIES_TERMS; gi++) begin : g_ser
        localparam int K = SERIES_TERMS - gi;
        ttrig_series_cell #(.D((2 * K) * (2 * K - 1))) u_cos (
            .i_clk (i_clk),
            .i_x2  (w_cx[gi]),
            .i_t   (w_ct[gi]),
            .o_x2  (w_cx[gi+1]),
            .o_t   (w_ct[gi+1])
        );
        ttrig_series_cell #(.D((2 * K) * (2 * K - 1))) u_sin (
            .i_clk (i_clk),
            .i_x2  (w_sx[gi]),
            .i_t   (w_st[gi]),
            .o_x2  (w_sx[gi+1]),
            .o_t   (w_st[gi+1])
        );
    end

    // quotient operands
    always_comb begin
        if (r_ctl[P-1].action == ACT_TAN) begin
            n_num = w_st[SERIES_TERMS];
            n_den = w_ct[SERIES_TERMS];
        end else begin
            n_num = w_ct[SERIES_TERMS];
            n_den = w_st[SERIES_TERMS];
        end
        n_nmag = n_num[T_W-1] ? T_W'(-n_num) : T_W'(n_num);
        n_dmag = n_den[T_W-1] ? T_W'(-n_den) : T_W'(n_den);
    end

    always_ff @(posedge i_clk) begin
        r_pnum <= {n_nmag[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        r_pden <= n_dmag[DEN_W-1:0];
    end

    // control line
    always_comb begin
        n_ctl[0]        = '0;
        n_ctl[0].valid  = start;
        n_ctl[0].action = i_action;
        n_ctl[0].asign  = i_angle[DATA_WIDTH-1];
        for (int i = 1; i < L; i++) begin
            n_ctl[i] = r_ctl[i-1];
        end
        n_ctl[P].val  = (r_ctl[P-1].action == ACT_SIN) ? w_st[SERIES_TERMS]
                                                       : w_ct[SERIES_TERMS];
        n_ctl[P].nneg = n_num[T_W-1];
        n_ctl[P].qneg = n_num[T_W-1] ^ n_den[T_W-1];
        n_ctl[P].dz   = (n_den == '0);
    end

    for (gi = 0; gi < L; gi++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[gi] <= '0;
            end else begin
                r_ctl[gi] <= n_ctl[gi];
            end
        end
    end

    // quotient chain
    assign w_rem[0] = '0;
    assign w_num[0] = r_pnum;
    assign w_quo[0] = '0;
    assign w_den[0] = r_pden;

    for (gi = 0; gi < NUM_W; gi++) begin : g_div
        ttrig_div_cell u_cell (
            .i_clk (i_clk),
            .i_rem (w_rem[gi]),
            .i_num (w_num[gi]),
            .i_quo (w_quo[gi]),
            .i_den (w_den[gi]),
            .o_rem (w_rem[gi+1]),
            .o_num (w_num[gi+1]),
            .o_quo (w_quo[gi+1]),
            .o_den (w_den[gi+1])
        );
    end

    // select, clamp and register the result beat
    assign w_last = r_ctl[L-1];

    always_comb begin
        n_sat = 1'b0;
        if (w_last.action == ACT_COS || w_last.action == ACT_SIN) begin
            n_v = 65'(w_last.val);
        end else if (w_last.qneg) begin
            n_v = -$signed({14'd0, w_quo[NUM_W]});
        end else begin
            n_v = $signed({14'd0, w_quo[NUM_W]});
        end
        if ((w_last.action == ACT_TAN || w_last.action == ACT_COT) && w_last.dz) begin
            n_sat   = 1'b1;
            n_value = w_last.nneg ? WMIN[DATA_WIDTH-1:0] : WMAX[DATA_WIDTH-1:0];
        end else if (n_v > WMAX) begin
            n_sat   = 1'b1;
            n_value = WMAX[DATA_WIDTH-1:0];
        end else if (n_v < WMIN) begin
            n_sat   = 1'b1;
            n_value = WMIN[DATA_WIDTH-1:0];
        end else begin
            n_value = n_v[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.valid;
        end
        r_value <= n_value;
        r_sat   <= n_sat;
    end

    assign o_valid     = r_valid;
    assign o_value     = r_value;
    assign o_saturated = r_sat;
endmodule

>>> src/ttrig_mod_cell.sv
// One step of the angle reduction chain: drop one shifted multiple of two pi.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module ttrig_mod_cell #(
    parameter int          MW  = 32,
    parameter logic [63:0] SUB = 64'd0
) (
    input  logic          i_clk,
    input  logic [MW-1:0] i_mag,
    output logic [MW-1:0] o_mag
);
    localparam logic [MW-1:0] SUBV = SUB[MW-1:0];

    logic [MW-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (i_mag >= SUBV) begin
            r_mag <= i_mag - SUBV;
        end else begin
            r_mag <= i_mag;
        end
    end

    assign o_mag = r_mag;
endmodule

>>> src/ttrig_series_cell.sv
// One Horner step of the cosine series: t = one - trunc(x2 * t / (d * one)).
// Three register stages; the divide by d is a reciprocal multiply. Uses ttrig_pkg.
`timescale 1ns / 1ps
module ttrig_series_cell #(
    parameter int D = 2
) (
    input  logic                           i_clk,
    input  logic [ttrig_pkg::X2_W-1:0]     i_x2,
    input  logic signed [ttrig_pkg::T_W-1:0] i_t,
    output logic [ttrig_pkg::X2_W-1:0]     o_x2,
    output logic signed [ttrig_pkg::T_W-1:0] o_t
);
    import ttrig_pkg::*;

    localparam logic [63:0]   RECIP = (64'd1 << NB) / D;
    localparam logic [NB-1:0] RV    = RECIP[NB-1:0];
    localparam logic [NB-1:0] DV    = NB'(D);
    localparam int            PW    = X2_W + T_W + 1;

    logic signed [PW-1:0] r_p;
    logic [X2_W-1:0]      r_x2a;
    logic [NB-1:0]        r_n;
    logic [NB-1:0]        r_e;
    logic                 r_neg;
    logic [X2_W-1:0]      r_x2b;
    logic signed [T_W-1:0] r_t;
    logic [X2_W-1:0]      r_x2c;

    logic [PW-1:0]   n_mag;
    logic [2*NB-1:0] n_prod;
    logic [2*NB-1:0] n_ed;
    logic [NB-1:0]   n_rem;
    logic [NB-1:0]   n_q;

    always_comb begin
        n_mag  = r_p[PW-1] ? PW'(-r_p) : PW'(r_p);
        n_prod = {{NB{1'b0}}, n_mag[PW-1:FRAC_BITS]} * {{NB{1'b0}}, RV};
        n_ed   = {{NB{1'b0}}, r_e} * {{NB{1'b0}}, DV};
        n_rem  = r_n - n_ed[NB-1:0];
        n_q    = (n_rem >= DV) ? r_e + NB'(1) : r_e;
    end

    always_ff @(posedge i_clk) begin
        r_p   <= $signed({1'b0, i_x2}) * i_t;
        r_x2a <= i_x2;
        r_n   <= n_mag[PW-1:FRAC_BITS];
        r_e   <= n_prod[2*NB-1:NB];
        r_neg <= r_p[PW-1];
        r_x2b <= r_x2a;
        if (r_neg) begin
            r_t <= $signed(ONE_Q + n_q[T_W-1:0]);
        end else begin
            r_t <= $signed(ONE_Q - n_q[T_W-1:0]);
        end
        r_x2c <= r_x2b;
    end

    assign o_x2 = r_x2c;
    assign o_t  = r_t;
endmodule

>>> src/ttrig_div_cell.sv
// One restoring step of the quotient chain: one quotient bit per cell.
// Uses ttrig_pkg for the operand widths.
`timescale 1ns / 1ps
module ttrig_div_cell (
    input  logic                        i_clk,
    input  logic [ttrig_pkg::DEN_W-1:0] i_rem,
    input  logic [ttrig_pkg::NUM_W-1:0] i_num,
    input  logic [ttrig_pkg::NUM_W-1:0] i_quo,
    input  logic [ttrig_pkg::DEN_W-1:0] i_den,
    output logic [ttrig_pkg::DEN_W-1:0] o_rem,
    output logic [ttrig_pkg::NUM_W-1:0] o_num,
    output logic [ttrig_pkg::NUM_W-1:0] o_quo,
    output logic [ttrig_pkg::DEN_W-1:0] o_den
);
    import ttrig_pkg::*;

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   n_sh;
    logic             n_ge;

    always_comb begin
        n_sh = {i_rem, i_num[NUM_W-1]};
        n_ge = (n_sh >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_ge ? DEN_W'(n_sh - {1'b0, i_den}) : n_sh[DEN_W-1:0];
        r_num <= {i_num[NUM_W-2:0], 1'b0};
        r_quo <= {i_quo[NUM_W-2:0], n_ge};
        r_den <= i_den;
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_den = r_den;
endmodule
